// File: hdl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/c8_pkg.sv
// ----------------------------------------------------------------------------
// CHIP-8 core package
// Payload types, mode and error codes shared by the core.
// ----------------------------------------------------------------------------
package c8_pkg;
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STEP = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OPCODE = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd3;
  localparam logic [11:0] PC_RESET = 12'h200;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
    logic [5:0]  pixel_x;
    logic [4:0]  pixel_y;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] executed_word;
    logic        pixel_value;
    logic        collision;
    logic        waiting_key;
    logic [1:0]  error_code;
  } out_beat_t;
endpackage

// File: hdl/chip8_instruction_core.sv
// A load writes main memory, a read fetches one screen pixel, and a step fetches both opcode bytes
// and executes; a return, Fx33, Fx55/Fx65, 00E0 (a screen sweep) and a draw (row by row, column by
// column, with a screen write for each lit pixel) pass through further states before the result.
// Throughput: one item at a time; a new item is taken only after the previous result is accepted.
// Reset: clears registers, stack level and timers; PC and program_start take PC_RESET (0x200).
// After reset the screen memory is swept clear, all 2048 pixels, with input held.
// ----------------------------------------------------------------------------
// CHIP-8 instruction core
// Sequencer over main, screen and stack memories executing one item at a time.
// ----------------------------------------------------------------------------
module chip8_instruction_core
  import c8_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [11:0] cfg_data_i
);
  localparam int SpW = $clog2(STACK_DEPTH + 1);
  localparam int SaW = $clog2(STACK_DEPTH);

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_F0 = 5'd2, S_F1 = 5'd3,
    S_F2 = 5'd4, S_EX = 5'd5, S_RET = 5'd6, S_DRR = 5'd7, S_DRW = 5'd8,
    S_DPX = 5'd9, S_DPW = 5'd10, S_BLK = 5'd11, S_BLR = 5'd12, S_BCD = 5'd13,
    S_RD = 5'd14, S_RD2 = 5'd15, S_OUT = 5'd16, S_LD = 5'd17, S_DRX = 5'd18;

  logic [4:0] st_q, st_d;
  in_beat_t it_q, it_d;
  out_beat_t ob_q, ob_d;
  logic [11:0] pc_q, pc_d, ir_q, ir_d, pstart_q, pstart_d;
  logic [7:0] v_q [16];
  logic [7:0] v_d [16];
  logic [7:0] dt_q, dt_d, st8_q, st8_d, row_q, row_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [15:0] w_q, w_d;
  logic [10:0] ca_q, ca_d;
  logic [3:0] r_q, r_d;
  logic [3:0] c_q, c_d;
  logic [7:0] hi_q, hi_d;
  logic hit_q, hit_d;

  logic mwe, swe, swd, srd, kwe;
  logic [11:0] mwa, mra;
  logic [7:0] mwd, mrd;
  logic [10:0] swa, sra;
  logic [SaW-1:0] kwa, kra;
  logic [11:0] kwd, krd;

  c8_ram #(.Width(8), .Depth(4096)) u_mem (.clk_i, .we_i(mwe), .waddr_i(mwa),
    .wdata_i(mwd), .raddr_i(mra), .rdata_o(mrd));
  c8_ram #(.Width(1), .Depth(2048)) u_scr (.clk_i, .we_i(swe), .waddr_i(swa),
    .wdata_i(swd), .raddr_i(sra), .rdata_o(srd));
  c8_ram #(.Width(12), .Depth(STACK_DEPTH)) u_stk (.clk_i, .we_i(kwe), .waddr_i(kwa),
    .wdata_i(kwd), .raddr_i(kra), .rdata_o(krd));

  assign in_ready_o = (st_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (st_q == S_IDLE) || ((st_q == S_CLR) && (w_q != 16'h00E0));
  assign out_valid_o = (st_q == S_OUT);
  assign out_data_o = ob_q;

  logic [3:0] wx, wy, wn, key;
  logic [7:0] vx, vy, kk, sum8, dif8, bx, by;
  logic [8:0] add9;
  logic [11:0] nnn, pc2, pc4;
  logic [5:0] x0;
  logic [4:0] y0;
  logic [6:0] px;
  logic [5:0] py;
  logic [13:0] bmul;
  logic [14:0] tmul;
  logic [3:0] tens;

  always_comb begin
    wx = w_q[11:8]; wy = w_q[7:4]; wn = w_q[3:0];
    kk = w_q[7:0]; nnn = w_q[11:0];
    vx = v_q[wx]; vy = v_q[wy];
    pc2 = pc_q + 12'd2; pc4 = pc_q + 12'd4;
    add9 = {1'b0, vx} + {1'b0, vy};
    sum8 = vx + kk; dif8 = vx - vy;
    x0 = vx[5:0]; y0 = vy[4:0];
    px = {1'b0, x0} + {3'b0, c_q};
    py = {1'b0, y0} + {2'b0, r_q};
    key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (it_q.key_mask[k]) key = 4'(k);
    end
    bmul = ({6'd0, vx} * 14'd41) >> 12;
    bx = 8'(bmul);
    by = vx - 8'(bmul[1:0]) * 8'd100;
    tmul = {7'd0, by} * 15'd205;
    tens = tmul[14:11];
  end

  always_comb begin
    st_d = st_q; it_d = it_q; ob_d = ob_q; pc_d = pc_q; ir_d = ir_q;
    pstart_d = pstart_q; v_d = v_q; dt_d = dt_q; st8_d = st8_q; sp_d = sp_q;
    w_d = w_q; ca_d = ca_q; r_d = r_q; c_d = c_q; row_d = row_q; hi_d = hi_q;
    hit_d = hit_q;
    mwe = 1'b0; mwa = '0; mwd = '0; mra = pc_q;
    swe = 1'b0; swa = ca_q; swd = 1'b0; sra = ca_q;
    kwe = 1'b0; kwa = '0; kwd = pc2; kra = SaW'(sp_q - 1'b1);
    if (cfg_valid_i && cfg_ready_o) begin
      pstart_d = cfg_data_i; pc_d = cfg_data_i;
    end
    unique case (st_q)
      S_CLR: begin
        swe = 1'b1;
        ca_d = ca_q + 1'b1;
        if (&ca_q) begin
          st_d = (w_q == 16'h00E0) ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        ob_d = '0;
        if (in_valid_i && in_ready_o) begin
          it_d = in_data_i;
          unique case (in_data_i.mode)
            MODE_LOAD: st_d = S_LD;
            MODE_STEP: st_d = S_F0;
            MODE_READ: st_d = S_RD;
            default: begin
              ob_d.program_counter = pc_q;
              st_d = S_OUT;
            end
          endcase
        end
      end
      S_LD: begin
        mwe = 1'b1; mwa = it_q.load_address; mwd = it_q.load_data;
        ob_d.program_counter = pc_q; st_d = S_OUT;
      end
      S_RD: begin
        sra = {it_q.pixel_y, it_q.pixel_x}; st_d = S_RD2;
      end
      S_RD2: begin
        ob_d.pixel_value = srd; ob_d.program_counter = pc_q; st_d = S_OUT;
      end
      S_F0: begin
        mra = pc_q; st_d = S_F1;
      end
      S_F1: begin
        hi_d = mrd; mra = pc_q + 12'd1; st_d = S_F2;
      end
      S_F2: begin
        w_d = {hi_q, mrd}; st_d = S_EX;
      end
      S_EX: begin
        ob_d.executed_word = w_q;
        ob_d.error_code = ERR_NONE;
        pc_d = pc2;
        st_d = S_OUT;
        unique case (w_q[15:12])
          4'h0: begin
            if (nnn == 12'h0E0) begin
              ca_d = '0; st_d = S_CLR;
            end else if (nnn == 12'h0EE) begin
              if (sp_q == '0) ob_d.error_code = ERR_UNDERFLOW;
              else begin
                kra = SaW'(sp_q - 1'b1); sp_d = sp_q - 1'b1; st_d = S_RET;
              end
            end
          end
          4'h1: pc_d = nnn;
          4'h2: begin
            if (sp_q >= SpW'(STACK_DEPTH)) ob_d.error_code = ERR_OVERFLOW;
            else begin
              kwe = 1'b1; kwa = SaW'(sp_q); sp_d = sp_q + 1'b1; pc_d = nnn;
            end
          end
          4'h3: if (vx == kk) pc_d = pc4;
          4'h4: if (vx != kk) pc_d = pc4;
          4'h5, 4'h9: begin
            if (wn != 4'd0) ob_d.error_code = ERR_OPCODE;
            else if ((vx == vy) ^ w_q[15]) pc_d = pc4;
          end
          4'h6: v_d[wx] = kk;
          4'h7: v_d[wx] = sum8;
          4'h8: begin
            case (wn)
              4'h0: v_d[wx] = vy;
              4'h1: v_d[wx] = vx | vy;
              4'h2: v_d[wx] = vx & vy;
              4'h3: v_d[wx] = vx ^ vy;
              4'h4: begin v_d[wx] = add9[7:0]; v_d[15] = {7'd0, add9[8]}; end
              4'h5: begin v_d[wx] = dif8; v_d[15] = {7'd0, vx > vy}; end
              4'h6: begin v_d[wx] = vx >> 1; v_d[15] = {7'd0, vx[0]}; end
              4'h7: begin v_d[wx] = vy - vx; v_d[15] = {7'd0, vy > vx}; end
              4'hE: begin v_d[wx] = vx << 1; v_d[15] = {7'd0, vx[7]}; end
              default: ob_d.error_code = ERR_OPCODE;
            endcase
          end
          4'hA: ir_d = nnn;
          4'hB: pc_d = {4'd0, v_q[0]} + nnn;
          4'hC: v_d[wx] = it_q.random_byte & kk;
          4'hD: begin
            r_d = '0; c_d = '0; hit_d = 1'b0;
            if (wn == 4'd0) v_d[15] = 8'd0;
            else st_d = S_DRR;
          end
          4'hE: begin
            if (kk == 8'h9E) begin
              if (it_q.key_mask[vx[3:0]]) pc_d = pc4;
            end else if (kk == 8'hA1) begin
              if (!it_q.key_mask[vx[3:0]]) pc_d = pc4;
            end else ob_d.error_code = ERR_OPCODE;
          end
          default: begin
            r_d = '0;
            case (kk)
              8'h07: v_d[wx] = dt_q;
              8'h0A: begin
                if (it_q.key_mask == '0) begin
                  pc_d = pc_q; ob_d.waiting_key = 1'b1;
                end else v_d[wx] = {4'd0, key};
              end
              8'h15: dt_d = vx;
              8'h18: st8_d = vx;
              8'h1E: ir_d = ir_q + {4'd0, vx};
              8'h29: ir_d = {6'd0, vx[3:0], 2'd0} + {8'd0, vx[3:0]};
              8'h33: begin
                mwe = 1'b1; mwa = ir_q; mwd = bx; st_d = S_BCD;
              end
              8'h55: st_d = S_BLK;
              8'h65: begin
                mra = ir_q; st_d = S_BLR;
              end
              default: ob_d.error_code = ERR_OPCODE;
            endcase
          end
        endcase
        ob_d.program_counter = pc_d;
      end
      S_RET: begin
        pc_d = krd; ob_d.program_counter = krd; st_d = S_OUT;
      end
      S_BCD: begin
        mwe = 1'b1;
        if (r_q == 4'd0) begin
          mwa = ir_q + 12'd1; mwd = {4'd0, tens}; r_d = 4'd1;
        end else begin
          mwa = ir_q + 12'd2; mwd = by - {4'd0, tens} * 8'd10; st_d = S_OUT;
        end
      end
      S_BLK: begin
        mwe = 1'b1; mwa = ir_q + {8'd0, r_q}; mwd = v_q[r_q];
        r_d = r_q + 1'b1;
        if (r_q == wx) st_d = S_OUT;
      end
      S_BLR: begin
        mra = ir_q + {8'd0, r_q} + 12'd1;
        v_d[r_q] = mrd; r_d = r_q + 1'b1;
        if (r_q == wx) st_d = S_OUT;
      end
      S_DRR: begin
        if (r_q == wn || py[5]) begin
          v_d[15] = {7'd0, hit_q}; ob_d.collision = hit_q; st_d = S_OUT;
        end else begin
          mra = ir_q + {8'd0, r_q}; c_d = '0; st_d = S_DRW;
        end
      end
      S_DRW: begin
        row_d = mrd; st_d = S_DPX;
      end
      S_DPX: begin
        if (c_q[3] || px[6]) begin
          r_d = r_q + 1'b1; st_d = S_DRR;
        end else if (row_q[3'd7 - c_q[2:0]]) begin
          ca_d = {py[4:0], px[5:0]}; sra = {py[4:0], px[5:0]}; st_d = S_DPW;
        end else c_d = c_q + 1'b1;
      end
      S_DPW: begin
        swe = 1'b1; swa = ca_q; swd = !srd;
        if (srd) hit_d = 1'b1;
        c_d = c_q + 1'b1; st_d = S_DPX;
      end
      S_OUT: begin
        if (out_ready_i) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; pc_q <= PC_RESET; pstart_q <= PC_RESET; ir_q <= '0;
      for (int k = 0; k < 16; k++) v_q[k] <= '0;
      dt_q <= '0; st8_q <= '0; sp_q <= '0; ca_q <= '0; w_q <= '0;
      r_q <= '0; c_q <= '0; hit_q <= 1'b0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; pstart_q <= pstart_d; ir_q <= ir_d; v_q <= v_d;
      dt_q <= dt_d; st8_q <= st8_d; sp_q <= sp_d; ca_q <= ca_d; w_q <= w_d;
      r_q <= r_d; c_q <= c_d; hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; ob_q <= ob_d; row_q <= row_d; hi_q <= hi_d;
  end
endmodule

// File: hdl/c8_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/c8_checker.sv
// ----------------------------------------------------------------------------
// CHIP-8 core port checker
// Checks handshake and result behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module c8_checker
  import c8_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_data_o
);
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `ASSERT_IMPL(a_no_overlap, out_valid_o, !in_ready_o)
  `ASSERT_IMPL(a_wait_no_err, out_valid_o && out_data_o.waiting_key, out_data_o.error_code == ERR_NONE)
  `ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind chip8_instruction_core c8_checker u_c8_checker (.clk_i, .rst_ni, .in_valid_i,
  .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o);
